### rtl/nec_pkg.sv
// ----------------------------------------------------------------------------
// nec_pkg
// Shared widths, codes and types of the epsilon-closure unit.
// ----------------------------------------------------------------------------
package nec_pkg;

    // Fixed field widths of the stream items.
    localparam int STATE_W   = 5;
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Default sizes of the automaton.
    localparam int DEF_NUM_STATES = 32;
    localparam int DEF_MAX_EDGES  = 64;

    // Operation codes carried in the low tuser bit.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result traffic from the walk controller to the output buffer.
    typedef struct packed {
        logic               load;    // a newly visited state
        logic [STATE_W-1:0] state;
        logic               finish;  // the walk is over, the held state is last
    } nec_res_t;

endpackage

### rtl/nec_ram.sv
// ----------------------------------------------------------------------------
// nec_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module nec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/nec_obuf.sv
// ----------------------------------------------------------------------------
// nec_obuf
// Result buffer: holds the newest closure state until it is known whether
// another follows, then passes it to the output register with its last flag.
// ----------------------------------------------------------------------------
module nec_obuf (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nec_pkg::nec_res_t                  res,
    output logic                               can_load,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nec_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import nec_pkg::*;

    logic               pend_valid_reg, pend_valid_next;
    logic               pend_last_reg, pend_last_next;
    logic [STATE_W-1:0] pend_state_reg, pend_state_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic [STATE_W-1:0] out_state_reg, out_state_next;
    logic               out_free;
    logic               move;

    assign out_free = !out_valid_reg || m_tready;
    // The held state moves on once its successor arrives or the walk has ended.
    assign move     = pend_valid_reg && out_free && (res.load || pend_last_reg);
    assign can_load = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        pend_state_next = pend_state_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_state_next  = out_state_reg;

        if (move)
        begin
            out_valid_next  = 1'b1;
            out_state_next  = pend_state_reg;
            out_last_next   = pend_last_reg;
            pend_valid_next = 1'b0;
            pend_last_next  = 1'b0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (res.load)
        begin
            pend_valid_next = 1'b1;
            pend_state_next = res.state;
            pend_last_next  = 1'b0;
        end
        else if (res.finish)
        begin
            pend_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_state_reg <= pend_state_next;
        out_state_reg  <= out_state_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATE_W){1'b0}}, out_state_reg};
    assign m_tlast  = out_last_reg;

endmodule

### rtl/nec_ctrl.sv
// ----------------------------------------------------------------------------
// nec_ctrl
// Edge insertion and depth-first walk sequencer around the list-head, edge
// pool and walk-stack memories.
// ----------------------------------------------------------------------------
module nec_ctrl #(
    parameter int NUM_STATES = nec_pkg::DEF_NUM_STATES,
    parameter int MAX_EDGES  = nec_pkg::DEF_MAX_EDGES,
    parameter int SIW        = $clog2(NUM_STATES),
    parameter int EIW        = $clog2(MAX_EDGES),
    parameter int EW         = $clog2(MAX_EDGES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nec_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [nec_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                              can_load,
    output nec_pkg::nec_res_t                 res,
    // list-head memory
    output logic                              head_wr_en,
    output logic [SIW-1:0]                    head_wr_addr,
    output logic [EW-1:0]                     head_wr_data,
    output logic                              head_rd_en,
    output logic [SIW-1:0]                    head_rd_addr,
    input  logic [EW-1:0]                     head_rd_data,
    // edge pool memory: next pointer above target state
    output logic                              pool_wr_en,
    output logic [EIW-1:0]                    pool_wr_addr,
    output logic [EW+nec_pkg::STATE_W-1:0]    pool_wr_data,
    output logic                              pool_rd_en,
    output logic [EIW-1:0]                    pool_rd_addr,
    input  logic [EW+nec_pkg::STATE_W-1:0]    pool_rd_data,
    // walk-stack memory
    output logic                              stk_wr_en,
    output logic [SIW-1:0]                    stk_wr_addr,
    output logic [EW-1:0]                     stk_wr_data,
    output logic                              stk_rd_en,
    output logic [SIW-1:0]                    stk_rd_addr,
    input  logic [EW-1:0]                     stk_rd_data
);
    import nec_pkg::*;

    localparam int DW = $clog2(NUM_STATES + 1);
    localparam logic [EW-1:0] EDGE_NULL = EW'(MAX_EDGES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_HEAD = 6'b000100,
        S_WALK = 6'b001000,
        S_EDGE = 6'b010000,
        S_POP  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [SIW-1:0]        from_reg, from_next;
    logic [STATE_W-1:0]    to_reg, to_next;
    logic [EW-1:0]         used_reg, used_next;
    logic [EW-1:0]         top_reg, top_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [NUM_STATES-1:0] visited_reg, visited_next;
    logic [NUM_STATES-1:0] head_valid_reg, head_valid_next;
    logic                  head_vld_q_reg, head_vld_q_next;

    logic               in_op;
    logic               in_eps;
    logic [STATE_W-1:0] in_from;
    logic [STATE_W-1:0] in_to;
    logic [SIW-1:0]     in_from_idx;
    logic               in_from_ok;
    logic               in_to_ok;
    logic [EW-1:0]      head_val;
    logic [STATE_W-1:0] edge_tgt;
    logic [EW-1:0]      edge_nxt;
    logic [SIW-1:0]     tgt_idx;
    logic               tgt_new;

    assign in_op       = s_tuser[0];
    assign in_eps      = s_tuser[1];
    assign in_from     = s_tdata[STATE_W-1:0];
    assign in_to       = s_tdata[2*STATE_W-1:STATE_W];
    assign in_from_idx = SIW'(in_from);
    assign in_from_ok  = 32'(in_from) < NUM_STATES;
    assign in_to_ok    = 32'(in_to) < NUM_STATES;

    // A head that was never written reads as the empty list.
    assign head_val = head_vld_q_reg ? head_rd_data : EDGE_NULL;
    assign edge_tgt = pool_rd_data[STATE_W-1:0];
    assign edge_nxt = pool_rd_data[STATE_W +: EW];
    assign tgt_idx  = SIW'(edge_tgt);
    assign tgt_new  = (32'(edge_tgt) < NUM_STATES) && !visited_reg[tgt_idx];

    assign s_tready = (state_reg == S_IDLE) && can_load;

    always_comb
    begin
        state_next      = state_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        used_next       = used_reg;
        top_next        = top_reg;
        depth_next      = depth_reg;
        visited_next    = visited_reg;
        head_valid_next = head_valid_reg;
        head_vld_q_next = head_vld_q_reg;

        res          = '0;
        head_wr_en   = 1'b0;
        head_wr_addr = from_reg;
        head_wr_data = used_reg;
        head_rd_en   = 1'b0;
        head_rd_addr = in_from_idx;
        pool_wr_en   = 1'b0;
        pool_wr_addr = used_reg[EIW-1:0];
        pool_wr_data = {head_val, to_reg};
        pool_rd_en   = 1'b0;
        pool_rd_addr = top_reg[EIW-1:0];
        stk_wr_en    = 1'b0;
        stk_wr_addr  = SIW'(depth_reg - DW'(1));
        stk_wr_data  = edge_nxt;
        stk_rd_en    = 1'b0;
        stk_rd_addr  = SIW'(depth_reg - DW'(2));

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (in_op == OP_INSERT)
                    begin
                        if (in_eps && in_from_ok && in_to_ok && (used_reg < EDGE_NULL))
                        begin
                            head_rd_en      = 1'b1;
                            head_rd_addr    = in_from_idx;
                            head_vld_q_next = head_valid_reg[in_from_idx];
                            from_next       = in_from_idx;
                            to_next         = in_to;
                            state_next      = S_INS;
                        end
                    end
                    else
                    begin
                        visited_next = '0;
                        if (in_from_ok)
                        begin
                            visited_next[in_from_idx] = 1'b1;
                            res.load        = 1'b1;
                            res.state       = in_from;
                            head_rd_en      = 1'b1;
                            head_rd_addr    = in_from_idx;
                            head_vld_q_next = head_valid_reg[in_from_idx];
                            depth_next      = DW'(1);
                            state_next      = S_HEAD;
                        end
                    end
                end
            end
            S_INS:
            begin
                // The new edge goes in front of the old list.
                pool_wr_en                = 1'b1;
                head_wr_en                = 1'b1;
                head_valid_next[from_reg] = 1'b1;
                used_next                 = used_reg + EW'(1);
                state_next                = S_IDLE;
            end
            S_HEAD:
            begin
                top_next   = head_val;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (top_reg >= used_reg)
                begin
                    // Current level has no edges left.
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                    begin
                        res.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        stk_rd_en  = 1'b1;
                        state_next = S_POP;
                    end
                end
                else
                begin
                    pool_rd_en = 1'b1;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (!tgt_new)
                begin
                    top_next   = edge_nxt;
                    state_next = S_WALK;
                end
                else if (can_load)
                begin
                    visited_next[tgt_idx] = 1'b1;
                    res.load              = 1'b1;
                    res.state             = edge_tgt;
                    if (32'(depth_reg) < NUM_STATES)
                    begin
                        // Save the remaining list of this level and descend.
                        stk_wr_en       = 1'b1;
                        head_rd_en      = 1'b1;
                        head_rd_addr    = tgt_idx;
                        head_vld_q_next = head_valid_reg[tgt_idx];
                        depth_next      = depth_reg + DW'(1);
                        state_next      = S_HEAD;
                    end
                    else
                    begin
                        top_next   = edge_nxt;
                        state_next = S_WALK;
                    end
                end
            end
            S_POP:
            begin
                top_next   = stk_rd_data;
                state_next = S_WALK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            depth_reg      <= '0;
            visited_reg    <= '0;
            head_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            depth_reg      <= depth_next;
            visited_reg    <= visited_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg       <= from_next;
        to_reg         <= to_next;
        top_reg        <= top_next;
        head_vld_q_reg <= head_vld_q_next;
    end

endmodule

### rtl/nfa_epsilon_closure_top.sv
// ----------------------------------------------------------------------------
// nfa_epsilon_closure_top
// Epsilon-closure unit: stores epsilon edges in linked adjacency lists and
// streams the depth-first closure of a queried state.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         tdata: from_state[4:0], to_state[9:5], zero pad
//                       tuser: opcode[0], edge_is_epsilon[1]
//  m_*       out        tdata: closure_state[4:0], zero pad; tlast: last_in_closure
//
// An epsilon insert that is stored first reads the list head of the source,
// then writes the new pool entry and the new head in the same cycle. Any
// other insert is done with its transfer.
// A query reads the pool entry of each stored edge examined, and for each
// state visited reads its list head, makes the empty check at the end of its
// level and reads the walk stack back; each walk step goes through the
// registered read port of the edge pool, list-head or walk-stack memory.
// Reset empties every list and the pool; no clearing pass is needed, since
// list heads carry a valid bit each and only pool entries in use are read.
// A stalled output holds the walk only when a new state is found while the
// previous one is still waiting; the last result of a query may wait in the
// output register while the next item is transferred.
//
module nfa_epsilon_closure_top #(
    parameter int NUM_STATES = nec_pkg::DEF_NUM_STATES,
    parameter int MAX_EDGES  = nec_pkg::DEF_MAX_EDGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // from_state [4:0], to_state [9:5], zero [15:10]
    input  logic [nec_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode [0], edge_is_epsilon [1]
    input  logic [nec_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // closure_state [4:0], zero [7:5]
    output logic [nec_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import nec_pkg::*;

    // Widths of state indexes, pool indexes and pool pointers (with null code).
    localparam int SIW = $clog2(NUM_STATES);
    localparam int EIW = $clog2(MAX_EDGES);
    localparam int EW  = $clog2(MAX_EDGES + 1);

    nec_res_t res;
    logic     can_load;

    logic                  head_wr_en;
    logic [SIW-1:0]        head_wr_addr;
    logic [EW-1:0]         head_wr_data;
    logic                  head_rd_en;
    logic [SIW-1:0]        head_rd_addr;
    logic [EW-1:0]         head_rd_data;

    logic                  pool_wr_en;
    logic [EIW-1:0]        pool_wr_addr;
    logic [EW+STATE_W-1:0] pool_wr_data;
    logic                  pool_rd_en;
    logic [EIW-1:0]        pool_rd_addr;
    logic [EW+STATE_W-1:0] pool_rd_data;

    logic                  stk_wr_en;
    logic [SIW-1:0]        stk_wr_addr;
    logic [EW-1:0]         stk_wr_data;
    logic                  stk_rd_en;
    logic [SIW-1:0]        stk_rd_addr;
    logic [EW-1:0]         stk_rd_data;

    // Head pointer of each state's adjacency list.
    nec_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_STATES),
        .AW    (SIW)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (head_wr_en),
        .wr_addr (head_wr_addr),
        .wr_data (head_wr_data),
        .rd_en   (head_rd_en),
        .rd_addr (head_rd_addr),
        .rd_data (head_rd_data)
    );

    // Edge pool: each entry holds its target state and the next entry.
    nec_ram #(
        .WIDTH (EW + STATE_W),
        .DEPTH (MAX_EDGES),
        .AW    (EIW)
    ) u_pool_ram (
        .clk     (clk),
        .wr_en   (pool_wr_en),
        .wr_addr (pool_wr_addr),
        .wr_data (pool_wr_data),
        .rd_en   (pool_rd_en),
        .rd_addr (pool_rd_addr),
        .rd_data (pool_rd_data)
    );

    // Pending list pointers of the levels below the current one.
    nec_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_STATES),
        .AW    (SIW)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    nec_ctrl #(
        .NUM_STATES (NUM_STATES),
        .MAX_EDGES  (MAX_EDGES),
        .SIW        (SIW),
        .EIW        (EIW),
        .EW         (EW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .can_load     (can_load),
        .res          (res),
        .head_wr_en   (head_wr_en),
        .head_wr_addr (head_wr_addr),
        .head_wr_data (head_wr_data),
        .head_rd_en   (head_rd_en),
        .head_rd_addr (head_rd_addr),
        .head_rd_data (head_rd_data),
        .pool_wr_en   (pool_wr_en),
        .pool_wr_addr (pool_wr_addr),
        .pool_wr_data (pool_wr_data),
        .pool_rd_en   (pool_rd_en),
        .pool_rd_addr (pool_rd_addr),
        .pool_rd_data (pool_rd_data),
        .stk_wr_en    (stk_wr_en),
        .stk_wr_addr  (stk_wr_addr),
        .stk_wr_data  (stk_wr_data),
        .stk_rd_en    (stk_rd_en),
        .stk_rd_addr  (stk_rd_addr),
        .stk_rd_data  (stk_rd_data)
    );

    // The buffer holds back each state until it knows whether it is the last.
    nec_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/nec_check.sv
// ----------------------------------------------------------------------------
// nec_check
// Port-level checks of the epsilon-closure unit, bound to the top level.
// ----------------------------------------------------------------------------
module nec_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [nec_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nec_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import nec_pkg::*;

    // A result waiting for the sink keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // A query occupies the unit while its walk starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == OP_QUERY) |=> !s_tready)
        else $error("input ready right after a query transfer");

    // Pad bits of a result stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:STATE_W] == '0))
        else $error("nonzero pad bits in result");

    // No result is shown in the first cycle after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid straight out of reset");

endmodule

bind nfa_epsilon_closure_top nec_check u_nec_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the epsilon-closure unit. Epsilon edges are inserted
// into the adjacency lists and closure queries are run. Every query is checked
// state by state against a model of the depth-first walk that this bench
// keeps. Random idle gaps and stalls are applied on both streams.
// ----------------------------------------------------------------------------
module tb;

    import nec_pkg::*;

    localparam int N_STATES    = DEF_NUM_STATES;
    localparam int POOL_SIZE   = DEF_MAX_EDGES;
    localparam int N_DIRECTED  = 22;
    localparam int RAND_ITEMS  = 240;
    localparam int HOLD_CYCLES = 150;
    // Sized for the longest walk over every pool entry and every state, with margin.
    localparam int TAIL_CYCLES = 250;
    localparam int STALL_LIMIT = 2000;

    // One closure state as it appears on the output stream.
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic               last;
    } closure_beat_t;

    // One row of the directed part. A row with known_result set is a query
    // whose closure is the single state known_state.
    typedef struct packed {
        logic               op;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic               eps;
        logic               known_result;
        logic [STATE_W-1:0] known_state;
    } stim_row_t;

    typedef struct {
        bit                 known_result;
        logic [STATE_W-1:0] known_state;
    } row_note_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    nfa_epsilon_closure_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Graph copy kept by the bench. A list head equal to POOL_SIZE is empty.
    logic [6:0]         adj_head    [N_STATES];
    logic [STATE_W-1:0] pool_target [POOL_SIZE];
    logic [6:0]         pool_next   [POOL_SIZE];
    int                 pool_used;

    closure_beat_t expected_closure_q [$];
    closure_beat_t walk_beats         [$];
    row_note_t     row_note_q         [$];
    stim_row_t     directed_rows      [N_DIRECTED];

    int errors;
    int n_inserts;
    int n_dropped;
    int n_queries;
    int n_beats;
    int widest_closure;
    int stall_cycles;
    bit idle_on;
    bit hold_req;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Walks the stored graph depth-first from root, newest edge first, and
    // leaves the closure in walk_beats in visit order.
    function automatic void walk_closure(input logic [STATE_W-1:0] root);
        logic [N_STATES-1:0] seen;
        logic [6:0]          pending [N_STATES];
        int                  depth;
        logic [6:0]          e;
        logic [STATE_W-1:0]  t;
        walk_beats.delete();
        seen       = '0;
        seen[root] = 1'b1;
        walk_beats.push_back({root, 1'b0});
        pending[0] = adj_head[root];
        depth      = 1;
        while (depth > 0) begin
            e = pending[depth-1];
            if (e >= pool_used) begin
                depth--;
            end
            else begin
                pending[depth-1] = pool_next[e];
                t = pool_target[e];
                if (!seen[t]) begin
                    seen[t] = 1'b1;
                    walk_beats.push_back({t, 1'b0});
                    if (depth < N_STATES) begin
                        pending[depth] = adj_head[t];
                        depth++;
                    end
                end
            end
        end
        walk_beats[walk_beats.size()-1].last = 1'b1;
    endfunction

    // Applies one accepted input item to the graph copy; a query leaves its
    // closure in walk_beats.
    function automatic void absorb_item(input logic op, input logic [STATE_W-1:0] src,
                                        input logic [STATE_W-1:0] dst, input logic eps);
        if (op == OP_INSERT) begin
            n_inserts++;
            if (eps) begin
                if (pool_used < POOL_SIZE) begin
                    pool_target[pool_used] = dst;
                    pool_next[pool_used]   = adj_head[src];
                    adj_head[src]          = 7'(pool_used);
                    pool_used++;
                end
                else begin
                    n_dropped++;
                end
            end
        end
        else begin
            n_queries++;
            walk_closure(src);
            if (walk_beats.size() > widest_closure)
                widest_closure = walk_beats.size();
        end
    endfunction

    function automatic void check_beat(input logic [STATE_W-1:0] got_state, input logic got_last);
        closure_beat_t want;
        if (expected_closure_q.size() == 0) begin
            $error("closure_state: unexpected transfer, expected none, actual %0d", got_state);
            errors++;
        end
        else begin
            want = expected_closure_q.pop_front();
            if (got_state !== want.state) begin
                $error("closure_state: expected %0d, actual %0d", want.state, got_state);
                errors++;
            end
            if (got_last !== want.last) begin
                $error("last_in_closure: expected %0b, actual %0b", want.last, got_last);
                errors++;
            end
        end
        n_beats++;
    endfunction

    // Both streams are sampled at the rising edge, before any of this edge's
    // updates land. Output transfers are checked before the input transfer of
    // the same edge adds its expectations.
    always @(posedge clk) begin : monitor_blk
        row_note_t note;
        if (rst_n) begin
            if (m_tvalid && m_tready)
                check_beat(m_tdata[STATE_W-1:0], m_tlast);
            if (s_tvalid && s_tready) begin
                note = row_note_q.pop_front();
                absorb_item(s_tuser[0], s_tdata[STATE_W-1:0],
                            s_tdata[2*STATE_W-1:STATE_W], s_tuser[1]);
                if (s_tuser[0] == OP_QUERY) begin
                    if (note.known_result)
                        expected_closure_q.push_back({note.known_state, 1'b1});
                    else
                        foreach (walk_beats[k])
                            expected_closure_q.push_back(walk_beats[k]);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither stream makes a transfer.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("nfa_epsilon_closure_top test failed");
            $finish;
        end
    end

    // Receiver: random runs of ready and random stalls, plus one long hold-off
    // on request so that the unit backs up and stalls its input.
    initial begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Presents one item and returns at the edge where it is transferred.
    task automatic offer_item(input logic op, input logic [STATE_W-1:0] src,
                              input logic [STATE_W-1:0] dst, input logic eps,
                              input bit known_result, input logic [STATE_W-1:0] known_state);
        row_note_q.push_back('{known_result, known_state});
        s_tdata  <= {{(S_TDATA_W-2*STATE_W){1'b0}}, dst, src};
        s_tuser  <= {eps, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Waits until every expected closure state has been received. The queue
    // is read at the falling edge, when the monitor is done with the cycle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_closure_q.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Random states lean toward a small cluster so that chains and cycles form
    // and closures get deep; the full range still shows up regularly.
    function automatic logic [STATE_W-1:0] pick_state();
        if ($urandom_range(0, 2) != 0)
            return STATE_W'($urandom_range(0, 9));
        return STATE_W'($urandom_range(0, N_STATES-1));
    endfunction

    initial begin
        logic               op;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic               eps;
        bit                 no_gaps;

        errors         = 0;
        n_inserts      = 0;
        n_dropped      = 0;
        n_queries      = 0;
        n_beats        = 0;
        widest_closure = 0;
        pool_used      = 0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        stall_cycles   = 0;
        foreach (adj_head[i])
            adj_head[i] = 7'(POOL_SIZE);

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;

        // Directed part. Single-state closures are typed in; the rest come
        // from the walk model.
        directed_rows = '{
            // Empty lists after reset, at both ends of the state range.
            '{OP_QUERY,  5'd0,  5'd0,  1'b0, 1'b1, 5'd0},
            '{OP_QUERY,  5'd31, 5'd31, 1'b1, 1'b1, 5'd31},
            // A non-epsilon edge is accepted and has no effect.
            '{OP_INSERT, 5'd0,  5'd1,  1'b0, 1'b0, 5'd0},
            '{OP_QUERY,  5'd0,  5'd0,  1'b0, 1'b1, 5'd0},
            // A self loop leads back to a visited state and is skipped.
            '{OP_INSERT, 5'd0,  5'd0,  1'b1, 1'b0, 5'd0},
            '{OP_QUERY,  5'd0,  5'd0,  1'b0, 1'b1, 5'd0},
            // Branches, a chain and a cycle back to the root.
            '{OP_INSERT, 5'd0,  5'd1,  1'b1, 1'b0, 5'd0},
            '{OP_INSERT, 5'd0,  5'd2,  1'b1, 1'b0, 5'd0},
            '{OP_INSERT, 5'd2,  5'd3,  1'b1, 1'b0, 5'd0},
            '{OP_INSERT, 5'd3,  5'd0,  1'b1, 1'b0, 5'd0},
            '{OP_INSERT, 5'd1,  5'd31, 1'b1, 1'b0, 5'd0},
            '{OP_QUERY,  5'd0,  5'd17, 1'b1, 1'b0, 5'd0},
            '{OP_QUERY,  5'd3,  5'd0,  1'b0, 1'b0, 5'd0},
            // A two-state cycle at the top of the range.
            '{OP_INSERT, 5'd31, 5'd30, 1'b1, 1'b0, 5'd0},
            '{OP_INSERT, 5'd30, 5'd31, 1'b1, 1'b0, 5'd0},
            '{OP_QUERY,  5'd31, 5'd0,  1'b0, 1'b0, 5'd0},
            '{OP_QUERY,  5'd30, 5'd0,  1'b0, 1'b0, 5'd0},
            // A state with no edges.
            '{OP_QUERY,  5'd5,  5'd0,  1'b0, 1'b1, 5'd5},
            '{OP_INSERT, 5'd31, 5'd0,  1'b1, 1'b0, 5'd0},
            '{OP_QUERY,  5'd1,  5'd0,  1'b0, 1'b0, 5'd0},
            '{OP_INSERT, 5'd31, 5'd31, 1'b0, 1'b0, 5'd0},
            '{OP_QUERY,  5'd2,  5'd31, 1'b1, 1'b0, 5'd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            offer_item(directed_rows[r].op, directed_rows[r].src, directed_rows[r].dst,
                       directed_rows[r].eps, directed_rows[r].known_result,
                       directed_rows[r].known_state);
            maybe_gap();
        end

        // Random part. Inserts fill the pool over the run; later epsilon
        // inserts hit a full pool and are dropped.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS - 40)
                idle_on = 1'b0;
            if (i == 90)
                hold_req = 1'b1;
            if (i == 160)
                wait_for_results();
            // A burst of queries without gaps while the receiver holds off.
            no_gaps = (i >= 90 && i < 106);
            if (no_gaps)
                op = OP_QUERY;
            else
                op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_QUERY;
            src = pick_state();
            dst = pick_state();
            eps = ($urandom_range(0, 9) < 8);
            offer_item(op, src, dst, eps, 1'b0, '0);
            if (!no_gaps)
                maybe_gap();
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d inserts (%0d epsilon edges stored, %0d dropped on a full pool)",
                 n_inserts, pool_used, n_dropped);
        $display("and %0d closure queries, %0d states checked, widest closure %0d states.",
                 n_queries, n_beats, widest_closure);
        if (errors == 0)
            $display("nfa_epsilon_closure_top test passed");
        else
            $display("nfa_epsilon_closure_top test failed");
        $finish;
    end

endmodule
